>>> design/keyboard_backlight_controller_defines.svh
// assertion macros for the keyboard backlight controller
// used by modules that check their own logic; no other dependencies
`ifndef KEYBOARD_BACKLIGHT_CONTROLLER_DEFINES_SVH
`define KEYBOARD_BACKLIGHT_CONTROLLER_DEFINES_SVH

// property that must hold at every clock edge outside reset
`define KBC_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked in the same cycle, outside reset
`define KBC_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> design/kbc_pkg.sv
// shared types, codes and tables for the keyboard backlight controller
// no dependencies
package kbc_pkg;

   // input transaction
   typedef struct packed {
      logic [2:0]  action;
      logic [7:0]  level_value;
      logic [1:0]  region;
      logic [23:0] rgb_color;
   } kbc_req_type;

   // result transaction
   typedef struct packed {
      logic [31:0] command_word;
      logic [7:0]  brightness_now;
      logic        last;
   } kbc_rsp_type;

   // action codes on the input channel
   localparam logic [2:0] ACT_SET_LEVEL    = 3'd0;
   localparam logic [2:0] ACT_TOGGLE       = 3'd1;
   localparam logic [2:0] ACT_STEP_DOWN    = 3'd2;
   localparam logic [2:0] ACT_STEP_UP      = 3'd3;
   localparam logic [2:0] ACT_NEXT_COLOR   = 3'd4;
   localparam logic [2:0] ACT_REGION_COLOR = 3'd5;

   // decoded operation carried from front to back
   typedef enum logic [2:0] {
      OP_SET_LEVEL,
      OP_TOGGLE,
      OP_STEP_DOWN,
      OP_STEP_UP,
      OP_NEXT_COLOR,
      OP_REGION_COLOR
   } kbc_op_code_type;

   typedef struct packed {
      kbc_op_code_type op;
      logic [7:0]      level_value;
      logic [1:0]      region;
      logic [23:0]     rgb_color;
   } kbc_op_type;

   // command word fields
   localparam logic [23:0] CMD_BRIGHT_PREFIX = 24'hF40000;
   localparam logic [3:0]  CMD_COLOR_PREFIX  = 4'hF;

   localparam logic [7:0] RESET_BRIGHTNESS = 8'd72;
   localparam logic [2:0] PALETTE_LAST     = 3'd6;
   localparam int         MAX_COLOR_CMDS   = 4;
   localparam int         LEVEL_TABLE_SIZE = 16;
   localparam int         QUEUE_DEPTH      = 2;

   function automatic logic [23:0] palette_color(input logic [2:0] idx);
      logic [23:0] c;
      case (idx)
         3'd0:    c = 24'hFFFFFF;
         3'd1:    c = 24'h0000FF;
         3'd2:    c = 24'hFF0000;
         3'd3:    c = 24'hFF00FF;
         3'd4:    c = 24'h00FF00;
         3'd5:    c = 24'h00FFFF;
         3'd6:    c = 24'hFFFF00;
         default: c = 24'hFFFFFF;
      endcase
      return c;
   endfunction

   // brightness step levels; entries past the fifth sit at full scale
   function automatic logic [7:0] level_entry(input logic [3:0] idx);
      logic [7:0] v;
      case (idx)
         4'd0:    v = 8'd48;
         4'd1:    v = 8'd72;
         4'd2:    v = 8'd96;
         4'd3:    v = 8'd144;
         4'd4:    v = 8'd192;
         default: v = 8'd255;
      endcase
      return v;
   endfunction

   // region color command: blue, red, green order in the low bits
   function automatic logic [31:0] color_word(input logic [3:0]  region,
                                              input logic [23:0] rgb);
      return {CMD_COLOR_PREFIX, region, rgb[7:0], rgb[23:16], rgb[15:8]};
   endfunction

endpackage

>>> design/kbc_queue.sv
// two-entry queue of decoded operations between front and back
// depends on kbc_pkg
module kbc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  kbc_pkg::kbc_op_type wr_data,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output kbc_pkg::kbc_op_type rd_data
);
   import kbc_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   kbc_op_type         entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> design/kbc_front.sv
// front end: takes input transactions, decodes the action, drops no-ops
// depends on kbc_pkg
module kbc_front #(
   parameter int NUM_REGIONS = 4
) (
   input  logic                 req_push,
   input  kbc_pkg::kbc_req_type req_data,
   output logic                 q_push,
   output kbc_pkg::kbc_op_type  q_data
);
   import kbc_pkg::*;

   logic keep;

   always_comb begin
      keep             = 1'b1;
      q_data.op        = OP_SET_LEVEL;
      q_data.level_value = req_data.level_value;
      q_data.region    = req_data.region;
      q_data.rgb_color = req_data.rgb_color;
      case (req_data.action)
         ACT_SET_LEVEL:  q_data.op = OP_SET_LEVEL;
         ACT_TOGGLE:     q_data.op = OP_TOGGLE;
         ACT_STEP_DOWN:  q_data.op = OP_STEP_DOWN;
         ACT_STEP_UP:    q_data.op = OP_STEP_UP;
         ACT_NEXT_COLOR: q_data.op = OP_NEXT_COLOR;
         ACT_REGION_COLOR: begin
            q_data.op = OP_REGION_COLOR;
            // region outside the fitted ones: nothing to send
            keep = ({3'b000, req_data.region} < 5'(NUM_REGIONS));
         end
         default: keep = 1'b0;
      endcase
   end

   assign q_push = req_push && keep;

endmodule

>>> design/kbc_back.sv
// back end: holds brightness and palette state, builds command words
// depends on kbc_pkg and keyboard_backlight_controller_defines.svh
`include "keyboard_backlight_controller_defines.svh"
module kbc_back #(
   parameter int NUM_REGIONS = 4,
   parameter int NUM_LEVELS  = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  kbc_pkg::kbc_op_type  q_data,
   output logic                 q_pop,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output kbc_pkg::kbc_rsp_type rsp_data
);
   import kbc_pkg::*;

   localparam int COLOR_CNT = (NUM_REGIONS > MAX_COLOR_CMDS) ? MAX_COLOR_CMDS : NUM_REGIONS;
   localparam int K_W       = $clog2(MAX_COLOR_CMDS);

   logic [7:0]     bright_ff, bright_in;
   logic [7:0]     saved_ff, saved_in;
   logic [2:0]     palette_ff, palette_in;
   logic [K_W-1:0] k_ff, k_in;
   logic           out_valid_ff, out_valid_in;
   kbc_rsp_type    out_ff, out_in;

   logic           out_free;
   logic [7:0]     down_level, up_level;
   logic           down_found, up_found;
   logic           do_toggle, set_level, emit;
   logic [7:0]     new_level;
   logic [2:0]     next_pal, cur_pal;
   logic           k_last;
   logic           head_is_color, out_mid, early_color;

   // neighbouring table levels, one compare per entry
   always_comb begin
      down_level = '0;
      down_found = 1'b0;
      for (int i = 0; i < LEVEL_TABLE_SIZE; i++) begin
         if (i < NUM_LEVELS && level_entry(4'(i)) < bright_ff) begin
            down_level = level_entry(4'(i));
            down_found = 1'b1;
         end
      end
      up_level = '0;
      up_found = 1'b0;
      for (int i = LEVEL_TABLE_SIZE - 1; i >= 0; i--) begin
         if (i < NUM_LEVELS && level_entry(4'(i)) > bright_ff) begin
            up_level = level_entry(4'(i));
            up_found = 1'b1;
         end
      end
   end

   assign out_free = !out_valid_ff || rsp_pop;
   assign next_pal = (palette_ff == PALETTE_LAST) ? 3'd0 : palette_ff + 3'd1;
   assign cur_pal  = (k_ff == '0) ? next_pal : palette_ff;
   assign k_last   = (k_ff == K_W'(COLOR_CNT - 1));

   always_comb begin
      bright_in    = bright_ff;
      saved_in     = saved_ff;
      palette_in   = palette_ff;
      k_in         = k_ff;
      q_pop        = 1'b0;
      do_toggle    = 1'b0;
      set_level    = 1'b0;
      emit         = 1'b0;
      new_level    = '0;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_pop;

      if (!q_empty && out_free) begin
         case (q_data.op)
            OP_SET_LEVEL: begin
               set_level = 1'b1;
               new_level = q_data.level_value;
            end
            OP_TOGGLE: do_toggle = 1'b1;
            OP_STEP_DOWN: begin
               if (bright_ff == '0) begin
                  do_toggle = 1'b1;
               end else if (down_found) begin
                  set_level = 1'b1;
                  new_level = down_level;
               end else begin
                  q_pop = 1'b1;
               end
            end
            OP_STEP_UP: begin
               if (bright_ff == '0) begin
                  do_toggle = 1'b1;
               end else if (up_found) begin
                  set_level = 1'b1;
                  new_level = up_level;
               end else begin
                  q_pop = 1'b1;
               end
            end
            OP_NEXT_COLOR: begin
               emit = 1'b1;
               palette_in = cur_pal;
               out_in.command_word   = color_word({{(4-K_W){1'b0}}, k_ff},
                                                  palette_color(cur_pal));
               out_in.brightness_now = bright_ff;
               out_in.last           = k_last;
               if (k_last) begin
                  k_in  = '0;
                  q_pop = 1'b1;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
            OP_REGION_COLOR: begin
               emit = 1'b1;
               out_in.command_word   = color_word({2'b00, q_data.region}, q_data.rgb_color);
               out_in.brightness_now = bright_ff;
               out_in.last           = 1'b1;
               q_pop = 1'b1;
            end
            default: q_pop = 1'b1;
         endcase

         if (do_toggle) begin
            set_level = 1'b1;
            if (bright_ff != '0) begin
               saved_in  = bright_ff;
               new_level = '0;
            end else begin
               new_level = saved_ff;
            end
         end

         if (set_level) begin
            emit      = 1'b1;
            bright_in = new_level;
            out_in.command_word   = {CMD_BRIGHT_PREFIX, new_level};
            out_in.brightness_now = new_level;
            out_in.last           = 1'b1;
            q_pop = 1'b1;
         end
      end

      if (emit) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bright_ff    <= RESET_BRIGHTNESS;
         saved_ff     <= RESET_BRIGHTNESS;
         palette_ff   <= '0;
         k_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         bright_ff    <= bright_in;
         saved_ff     <= saved_in;
         palette_ff   <= palette_in;
         k_ff         <= k_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   // terms for the checks below
   assign head_is_color = !q_empty && q_data.op == OP_NEXT_COLOR;
   assign out_mid       = out_valid_ff && !out_ff.last;
   assign early_color   = out_ff.command_word[31:28] == CMD_COLOR_PREFIX &&
                          out_ff.command_word[27:24] != 4'(COLOR_CNT - 1);

   `KBC_ALWAYS(a_palette_range, clock, reset, palette_ff <= PALETTE_LAST, "palette index high")
   `KBC_IMPLY(a_burst_on_color, clock, reset, k_ff != '0, head_is_color, "burst off color op")
   `KBC_IMPLY(a_nonlast_is_color, clock, reset, out_mid, early_color, "bad non-final result")

endmodule

>>> design/keyboard_backlight_controller.sv
// keyboard backlight controller top level: front decode, operation queue, back end
// depends on kbc_pkg, kbc_front, kbc_queue and kbc_back
//
// usage
//   input channel: a transaction is taken on a clock edge with req_push high and
//   req_full low; req_data carries action, level_value, region and rgb_color
//   result channel: while rsp_empty is low the oldest command word sits on
//   rsp_data; it is taken on an edge with rsp_pop high
//   path: with an idle back end the first command of an event goes from the queue
//   head through the back end into the output register and from there on rsp_data
//   rate: a brightness or region color event gives one command word; a next color
//   event gives min(NUM_REGIONS, 4) words, one per region; the back end emits one
//   command word per cycle into its output register while the receiver takes them
//   unused actions, out-of-range regions and steps past the table ends give
//   no result; decode drops the first two, the back end pops the steps unanswered
//   reset: brightness and saved brightness go to 72, palette index to 0, the
//   queue and the output register are emptied
//   receiver stall: the output register holds, the back end waits, the
//   two-entry queue fills and req_full rises; nothing is dropped
module keyboard_backlight_controller #(
   parameter int NUM_REGIONS = 4,
   parameter int NUM_LEVELS  = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  kbc_pkg::kbc_req_type req_data,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output kbc_pkg::kbc_rsp_type rsp_data
);
   import kbc_pkg::*;

   // decoded operation into the queue
   logic       q_push;
   kbc_op_type q_wr_data;
   // head of the queue toward the back end
   logic       q_empty;
   logic       q_pop;
   kbc_op_type q_rd_data;

   // front: classify, drop events that never produce a command
   kbc_front #(
      .NUM_REGIONS (NUM_REGIONS)
   ) u_front (
      .req_push (req_push),
      .req_data (req_data),
      .q_push   (q_push),
      .q_data   (q_wr_data)
   );

   // short queue decoupling front and back; its full flag is the input backpressure
   kbc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (q_wr_data),
      .full    (req_full),
      .pop     (q_pop),
      .empty   (q_empty),
      .rd_data (q_rd_data)
   );

   // back: state update and command generation into the output register
   kbc_back #(
      .NUM_REGIONS (NUM_REGIONS),
      .NUM_LEVELS  (NUM_LEVELS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_rd_data),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
